// ----- design/grc_pkg.sv -----
// ----------------------------------------------------------------------------
// grc_pkg
// shared types and constants of the column ray caster
// ----------------------------------------------------------------------------
package grc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MAP_SIZE   = 64;
	localparam int WALK_LIMIT = 2 * MAP_SIZE;
	localparam int DIV_STEPS  = 33;

	localparam logic [22:0] DIST_MIN  = 23'd7;
	localparam logic [22:0] PERP_MAX  = 23'd8388607;
	localparam logic [25:0] SLICE_MAX = 26'd40960000;

	localparam logic [2:0] REG_POS_X  = 3'd0;
	localparam logic [2:0] REG_POS_Y  = 3'd1;
	localparam logic [2:0] REG_DIR_X  = 3'd2;
	localparam logic [2:0] REG_DIR_Y  = 3'd3;
	localparam logic [2:0] REG_PLN_X  = 3'd4;
	localparam logic [2:0] REG_PLN_Y  = 3'd5;
	localparam logic [2:0] REG_WIDTH  = 3'd6;
	localparam logic [2:0] REG_HEIGHT = 3'd7;

	localparam logic [1:0] TILE_OPEN = 2'd0;
	localparam logic [1:0] TILE_WALL = 2'd1;
	localparam logic [1:0] TILE_DOOR = 2'd2;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef enum logic [1:0] {
		DIV_CAM,
		DIV_DX,
		DIV_DY,
		DIV_LINE
	} div_sel_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CAM_GO,
		ST_CAM_WAIT,
		ST_RAY_MUL,
		ST_RAY_LD,
		ST_DX_GO,
		ST_DX_WAIT,
		ST_DY_GO,
		ST_DY_WAIT,
		ST_SD_MUL,
		ST_STEP,
		ST_CHECK,
		ST_PERP,
		ST_LINE_GO,
		ST_LINE_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic        clr_we;
		logic [11:0] clr_addr;
		logic        item_ld;
		logic        div_start;
		div_sel_t    div_sel;
		logic        div_take;
		logic        mul_go;
		logic [2:0]  mul_idx;
		logic        ray_ld;
		logic        step;
		logic        check;
		logic        perp_ld;
		logic        out_ld;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
		logic hit;
		logic out_busy;
	} status_t;

endpackage

// ----- design/grc_div.sv -----
// ----------------------------------------------------------------------------
// grc_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module grc_div
	import grc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] num,
	input  logic [34:0] den,
	output logic        busy,
	output logic [32:0] quo
);

	logic [5:0]  cnt_q;
	logic [32:0] num_q;
	logic [34:0] den_q;
	logic [34:0] rem_q;
	logic [32:0] quo_q;
	logic [35:0] trial;
	logic [35:0] diff;
	logic        ge;

	assign busy  = (cnt_q != 6'd0);
	assign quo   = quo_q;
	assign trial = {rem_q, num_q[32]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'(DIV_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[31:0], 1'b0};
			rem_q <= ge ? diff[34:0] : trial[34:0];
			quo_q <= {quo_q[31:0], ge};
		end
	end

endmodule

// ----- design/grc_dp.sv -----
// ----------------------------------------------------------------------------
// grc_dp
// datapath: registers, tile map, shared multiplier and divider, dda walk
// ----------------------------------------------------------------------------
module grc_dp
	import grc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     sts,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [21:0] cfg_data,
	input  logic        s_tuser,
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata
);

	logic [21:0] pos_x_q, pos_y_q;
	logic [18:0] view_dir_x_q, view_dir_y_q, plane_x_q, plane_y_q;
	logic [12:0] win_width_q, win_height_q;
	logic [12:0] w, h;

	logic [1:0]  mem [MAP_SIZE*MAP_SIZE];
	logic [1:0]  tile_q;
	logic        mem_we;
	logic [11:0] mem_waddr, mem_raddr;
	logic [1:0]  mem_wdata;

	logic [11:0] col_q;
	logic signed [30:0] cam_q;
	logic signed [50:0] acc_x_q, acc_y_q;
	logic signed [50:0] ray_x_w, ray_y_w;
	logic [35:0] rdx_q, rdy_q;
	logic [35:0] ax_full, ay_full;
	logic [34:0] abs_x, abs_y;
	logic [36:0] dx_q, dy_q;
	logic [43:0] sd_x_q, sd_y_q;
	logic [16:0] fr_x, fr_y;

	logic [21:0] mul_a;
	logic [17:0] mul_b;
	logic signed [39:0] prod_s1;
	logic [2:0]  pidx_s1;
	logic        pval_s1;

	logic        div_busy;
	logic [32:0] div_num, div_quo;
	logic [34:0] div_den;

	logic signed [8:0] mx_q, my_q, nmx, nmy;
	logic        side_q, kind_q, step_x, oob;
	logic [43:0] pdiff;
	logic [22:0] perp_q;
	logic [25:0] line_q;

	logic [11:0] h2, ds_w;
	logic [24:0] l2;
	logic [25:0] de_sum;
	logic [12:0] de_w;
	logic [5:0]  cx_w, cy_w;

	logic        m_tvalid_q;
	logic [87:0] m_tdata_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q      <= '0;
			pos_y_q      <= '0;
			view_dir_x_q <= 19'd65536;
			view_dir_y_q <= '0;
			plane_x_q    <= '0;
			plane_y_q    <= 19'd43254;
			win_width_q  <= 13'd640;
			win_height_q <= 13'd480;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POS_X:  pos_x_q      <= cfg_data;
				REG_POS_Y:  pos_y_q      <= cfg_data;
				REG_DIR_X:  view_dir_x_q <= cfg_data[18:0];
				REG_DIR_Y:  view_dir_y_q <= cfg_data[18:0];
				REG_PLN_X:  plane_x_q    <= cfg_data[18:0];
				REG_PLN_Y:  plane_y_q    <= cfg_data[18:0];
				REG_WIDTH:  win_width_q  <= cfg_data[12:0];
				REG_HEIGHT: win_height_q <= cfg_data[12:0];
				default:    pos_x_q      <= pos_x_q;
			endcase
		end
	end

	assign w = (win_width_q == 13'd0) ? 13'd1 :
		(win_width_q > 13'd4096) ? 13'd4096 : win_width_q;
	assign h = (win_height_q == 13'd0) ? 13'd1 :
		(win_height_q > 13'd4096) ? 13'd4096 : win_height_q;

	// tile map
	assign mem_we    = cmd.clr_we | (cmd.item_ld & (s_tuser == OP_WRITE));
	assign mem_waddr = cmd.clr_we ? cmd.clr_addr : {s_tdata[23:18], s_tdata[17:12]};
	assign mem_wdata = cmd.clr_we ? TILE_OPEN : s_tdata[25:24];

	assign step_x = (sd_x_q < sd_y_q);
	assign nmx = step_x ? (rdx_q[35] ? mx_q - 9'sd1 : mx_q + 9'sd1) : mx_q;
	assign nmy = step_x ? my_q : (rdy_q[35] ? my_q - 9'sd1 : my_q + 9'sd1);
	assign mem_raddr = {nmy[5:0], nmx[5:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		tile_q <= mem[mem_raddr];
	end

	// shared divider
	always_comb begin
		unique case (cmd.div_sel)
			DIV_CAM: begin
				div_num = {4'b0, col_q, 17'b0};
				div_den = {22'b0, w};
			end
			DIV_DX: begin
				div_num = 33'h1_0000_0000;
				div_den = abs_x;
			end
			DIV_DY: begin
				div_num = 33'h1_0000_0000;
				div_den = abs_y;
			end
			default: begin
				div_num = {4'b0, h, 16'b0};
				div_den = {12'b0, perp_q};
			end
		endcase
	end

	grc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign ax_full = rdx_q[35] ? 36'(-rdx_q) : rdx_q;
	assign ay_full = rdy_q[35] ? 36'(-rdy_q) : rdy_q;
	assign abs_x   = ax_full[34:0];
	assign abs_y   = ay_full[34:0];

	// shared multiplier, camera products then side distance products
	assign fr_x = rdx_q[35] ? {1'b0, pos_x_q[15:0]} : 17'h10000 - {1'b0, pos_x_q[15:0]};
	assign fr_y = rdy_q[35] ? {1'b0, pos_y_q[15:0]} : 17'h10000 - {1'b0, pos_y_q[15:0]};

	always_comb begin
		case (cmd.mul_idx)
			3'd0: begin
				mul_a = {{3{plane_x_q[18]}}, plane_x_q};
				mul_b = {2'b0, cam_q[15:0]};
			end
			3'd1: begin
				mul_a = {{3{plane_x_q[18]}}, plane_x_q};
				mul_b = {{3{cam_q[30]}}, cam_q[30:16]};
			end
			3'd2: begin
				mul_a = {{3{plane_y_q[18]}}, plane_y_q};
				mul_b = {2'b0, cam_q[15:0]};
			end
			3'd3: begin
				mul_a = {{3{plane_y_q[18]}}, plane_y_q};
				mul_b = {{3{cam_q[30]}}, cam_q[30:16]};
			end
			3'd4: begin
				mul_a = {6'b0, dx_q[15:0]};
				mul_b = {1'b0, fr_x};
			end
			3'd5: begin
				mul_a = {1'b0, dx_q[36:16]};
				mul_b = {1'b0, fr_x};
			end
			3'd6: begin
				mul_a = {6'b0, dy_q[15:0]};
				mul_b = {1'b0, fr_y};
			end
			default: begin
				mul_a = {1'b0, dy_q[36:16]};
				mul_b = {1'b0, fr_y};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pval_s1 <= 1'b0;
		end else begin
			pval_s1 <= cmd.mul_go;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(mul_a) * $signed(mul_b);
		pidx_s1 <= cmd.mul_idx;
	end

	assign ray_x_w = $signed({{32{view_dir_x_q[18]}}, view_dir_x_q}) + (acc_x_q >>> FRAC_BITS);
	assign ray_y_w = $signed({{32{view_dir_y_q[18]}}, view_dir_y_q}) + (acc_y_q >>> FRAC_BITS);

	// walk and result datapath
	always_ff @(posedge clk) begin
		if (cmd.item_ld) begin
			col_q <= s_tdata[11:0];
		end
		if (cmd.div_take) begin
			case (cmd.div_sel)
				DIV_CAM:  cam_q  <= $signed({1'b0, div_quo[29:0]}) - 31'sd65536;
				DIV_DX:   dx_q   <= (abs_x == 35'd0) ? 37'h10_0000_0000 : {4'b0, div_quo};
				DIV_DY:   dy_q   <= (abs_y == 35'd0) ? 37'h10_0000_0000 : {4'b0, div_quo};
				default:  line_q <= (div_quo > {7'b0, SLICE_MAX}) ? SLICE_MAX : div_quo[25:0];
			endcase
		end
		if (pval_s1) begin
			case (pidx_s1)
				3'd0:    acc_x_q <= 51'(prod_s1);
				3'd1:    acc_x_q <= acc_x_q + (51'(prod_s1) <<< FRAC_BITS);
				3'd2:    acc_y_q <= 51'(prod_s1);
				3'd3:    acc_y_q <= acc_y_q + (51'(prod_s1) <<< FRAC_BITS);
				3'd4:    sd_x_q  <= {20'b0, prod_s1[39:16]};
				3'd5:    sd_x_q  <= sd_x_q + {4'b0, prod_s1};
				3'd6:    sd_y_q  <= {20'b0, prod_s1[39:16]};
				default: sd_y_q  <= sd_y_q + {4'b0, prod_s1};
			endcase
		end
		if (cmd.ray_ld) begin
			rdx_q <= ray_x_w[35:0];
			rdy_q <= ray_y_w[35:0];
			mx_q  <= {3'b0, pos_x_q[21:16]};
			my_q  <= {3'b0, pos_y_q[21:16]};
			side_q <= 1'b0;
			kind_q <= 1'b0;
		end
		if (cmd.step) begin
			mx_q <= nmx;
			my_q <= nmy;
			side_q <= !step_x;
			if (step_x) begin
				sd_x_q <= sd_x_q + {7'b0, dx_q};
			end else begin
				sd_y_q <= sd_y_q + {7'b0, dy_q};
			end
		end
		if (cmd.check) begin
			kind_q <= !oob && (tile_q == TILE_DOOR);
		end
		if (cmd.perp_ld) begin
			if (pdiff < {21'b0, DIST_MIN}) begin
				perp_q <= DIST_MIN;
			end else if (pdiff > {21'b0, PERP_MAX}) begin
				perp_q <= PERP_MAX;
			end else begin
				perp_q <= pdiff[22:0];
			end
		end
	end

	assign oob   = (mx_q[8:6] != 3'b0) || (my_q[8:6] != 3'b0);
	assign pdiff = side_q ? sd_y_q - {7'b0, dy_q} : sd_x_q - {7'b0, dx_q};

	assign h2     = h[12:1];
	assign l2     = line_q[25:1];
	assign ds_w   = ({13'b0, h2} > l2) ? h2 - l2[11:0] : 12'd0;
	assign de_sum = {1'b0, l2} + {14'b0, h2};
	assign de_w   = (de_sum >= {13'b0, h}) ? h - 13'd1 : de_sum[12:0];
	assign cx_w   = mx_q[8] ? 6'd0 : ((mx_q[7:6] != 2'b0) ? 6'd63 : mx_q[5:0]);
	assign cy_w   = my_q[8] ? 6'd0 : ((my_q[7:6] != 2'b0) ? 6'd63 : my_q[5:0]);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			m_tdata_q <= {1'b0, de_w[11:0], ds_w, line_q, perp_q, cy_w, cx_w, kind_q, side_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign sts.div_busy = div_busy;
	assign sts.hit      = oob || (tile_q == TILE_WALL) || (tile_q == TILE_DOOR);
	assign sts.out_busy = m_tvalid_q && !m_tready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> !(m_tvalid_q && !m_tready))
		else $error("result overwritten while held");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider started while busy");

	a_perp_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.perp_ld |=> (perp_q >= DIST_MIN))
		else $error("distance below floor");

endmodule

// ----- design/grc_ctrl.sv -----
// ----------------------------------------------------------------------------
// grc_ctrl
// sequencer for map clearing, map writes and column casts
// ----------------------------------------------------------------------------
module grc_ctrl
	import grc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	input  logic    s_tuser,
	output logic    s_tready,
	input  status_t sts,
	output cmd_t    cmd
);

	state_t      state_q, state_d;
	logic [11:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		s_tready = 1'b0;
		cmd      = '0;
		cmd.div_sel = DIV_CAM;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we   = 1'b1;
				cmd.clr_addr = cnt_q;
				cnt_d        = cnt_q + 12'd1;
				if (cnt_q == 12'(MAP_SIZE * MAP_SIZE - 1)) begin
					state_d = ST_IDLE;
					cnt_d   = '0;
				end
			end
			ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.item_ld = s_tvalid;
				if (s_tvalid && (s_tuser == OP_CAST)) begin
					state_d = ST_CAM_GO;
				end
			end
			ST_CAM_GO: begin
				cmd.div_start = 1'b1;
				state_d       = ST_CAM_WAIT;
			end
			ST_CAM_WAIT: begin
				if (!sts.div_busy) begin
					cmd.div_take = 1'b1;
					cnt_d        = '0;
					state_d      = ST_RAY_MUL;
				end
			end
			ST_RAY_MUL: begin
				cmd.mul_go  = (cnt_q < 12'd4);
				cmd.mul_idx = {1'b0, cnt_q[1:0]};
				cnt_d       = cnt_q + 12'd1;
				if (cnt_q == 12'd4) begin
					state_d = ST_RAY_LD;
				end
			end
			ST_RAY_LD: begin
				cmd.ray_ld = 1'b1;
				state_d    = ST_DX_GO;
			end
			ST_DX_GO: begin
				cmd.div_sel   = DIV_DX;
				cmd.div_start = 1'b1;
				state_d       = ST_DX_WAIT;
			end
			ST_DX_WAIT: begin
				cmd.div_sel = DIV_DX;
				if (!sts.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = ST_DY_GO;
				end
			end
			ST_DY_GO: begin
				cmd.div_sel   = DIV_DY;
				cmd.div_start = 1'b1;
				state_d       = ST_DY_WAIT;
			end
			ST_DY_WAIT: begin
				cmd.div_sel = DIV_DY;
				if (!sts.div_busy) begin
					cmd.div_take = 1'b1;
					cnt_d        = '0;
					state_d      = ST_SD_MUL;
				end
			end
			ST_SD_MUL: begin
				cmd.mul_go  = (cnt_q < 12'd4);
				cmd.mul_idx = {1'b1, cnt_q[1:0]};
				cnt_d       = cnt_q + 12'd1;
				if (cnt_q == 12'd4) begin
					cnt_d   = '0;
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				cmd.step = 1'b1;
				state_d  = ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				if (sts.hit || (cnt_q == 12'(WALK_LIMIT - 1))) begin
					state_d = ST_PERP;
				end else begin
					cnt_d   = cnt_q + 12'd1;
					state_d = ST_STEP;
				end
			end
			ST_PERP: begin
				cmd.perp_ld = 1'b1;
				state_d     = ST_LINE_GO;
			end
			ST_LINE_GO: begin
				cmd.div_sel   = DIV_LINE;
				cmd.div_start = 1'b1;
				state_d       = ST_LINE_WAIT;
			end
			ST_LINE_WAIT: begin
				cmd.div_sel = DIV_LINE;
				if (!sts.div_busy) begin
					cmd.div_take = 1'b1;
					state_d      = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- design/grid_ray_cast_column.sv -----
// input: a map write word goes to the tile map and the block stays ready for the next word;
// a cast word walks n grid steps (1 to 128) before its result is loaded for output
// throughput: one word at a time; a cast holds off the input until its result is loaded,
// set by four serial divisions on one shared divider and a step loop of ST_STEP and ST_CHECK
// reset: registers with a reset take their reset values, then a clearing pass over all
// 4096 cells sets the tile map to open cells; no input word is taken during that pass
// ----------------------------------------------------------------------------
// grid_ray_cast_column
// column ray caster walking a square tile map by dda
// ----------------------------------------------------------------------------
module grid_ray_cast_column
	import grc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [21:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,  // opcode
	input  logic [31:0] s_tdata,  // column, cell_x, cell_y, cell_kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata   // hit_side, hit_kind, hit_cell_x, hit_cell_y,
	                              // perp_distance, slice_height, first row, last row
);

	cmd_t    cmd;
	status_t sts;

	grc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	grc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
